// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/ttcw_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcw_pkg
// Types, codes and constants of the text terminal character writer.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;
	localparam int SCREENS_DEF = 3;

	localparam int KIND_W   = 2;
	localparam int SCREEN_W = 2;
	localparam int CHAR_W   = 8;
	localparam int RROW_W   = 5;
	localparam int RCOL_W   = 7;
	localparam int LIN_W    = 11;
	localparam int ATTR_W   = 8;

	localparam int NUM_REGS   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_ATTR0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTR1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTR2 = 2'd2;

	localparam logic [ATTR_W-1:0] ATTR0_RST = 8'h05;
	localparam logic [ATTR_W-1:0] ATTR1_RST = 8'h02;
	localparam logic [ATTR_W-1:0] ATTR2_RST = 8'h03;

	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUT   = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_CALC,
		ST_COPY,
		ST_DRAIN,
		ST_FILL,
		ST_RDWAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [SCREEN_W-1:0] screen;
		logic [CHAR_W-1:0]   chr;
		logic [RROW_W-1:0]   row;
		logic [RCOL_W-1:0]   col;
	} item_t;

	typedef struct packed {
		logic [RCOL_W-1:0] cur_col;
		logic [RROW_W-1:0] cur_row;
		logic [LIN_W-1:0]  cur_linear;
		logic [CHAR_W-1:0] cell_char;
		logic [ATTR_W-1:0] cell_attr;
		logic              scrolled;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/ttcw_if.sv =====
// ----------------------------------------------------------------------------
// ttcw_if
// Command and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttcw_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [ttcw_pkg::KIND_W-1:0]    kind;
	logic [ttcw_pkg::SCREEN_W-1:0]  screen_sel;
	logic [ttcw_pkg::CHAR_W-1:0]    char_byte;
	logic [ttcw_pkg::RROW_W-1:0]    read_row;
	logic [ttcw_pkg::RCOL_W-1:0]    read_col;

	modport source (output valid, kind, screen_sel, char_byte, read_row, read_col,
		input ready);
	modport sink (input valid, kind, screen_sel, char_byte, read_row, read_col,
		output ready);
endinterface

interface ttcw_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ttcw_pkg::RCOL_W-1:0]  cur_col;
	logic [ttcw_pkg::RROW_W-1:0]  cur_row;
	logic [ttcw_pkg::LIN_W-1:0]   cur_linear;
	logic [ttcw_pkg::CHAR_W-1:0]  cell_char;
	logic [ttcw_pkg::ATTR_W-1:0]  cell_attr;
	logic                         scrolled;

	modport source (output valid, cur_col, cur_row, cur_linear, cell_char, cell_attr,
		scrolled, input ready);
	modport sink (input valid, cur_col, cur_row, cur_linear, cell_char, cell_attr,
		scrolled, output ready);
endinterface

`default_nettype wire

// ===== rtl/ttcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttcw_ctrl
// Sequencer, cursor registers, address unit and cell memory.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_ctrl #(
	parameter int COLUMNS = ttcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = ttcw_pkg::ROWS_DEF,
	parameter int SCREENS = ttcw_pkg::SCREENS_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          item_valid,
	output logic                                               item_ready,
	input  wire ttcw_pkg::item_t                               item,
	input  wire logic [ttcw_pkg::NUM_REGS-1:0][ttcw_pkg::ATTR_W-1:0] attr,
	output logic                                               res_valid,
	input  wire logic                                          res_ready,
	output ttcw_pkg::result_t                                  res
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int DEPTH = SCREENS * CELLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SW    = (SCREENS > 1) ? $clog2(SCREENS) : 1;
	localparam int NW    = $clog2(CELLS + 1);

	ttcw_pkg::state_t state_q, state_d;
	ttcw_pkg::item_t  item_q, item_d;

	logic [CW-1:0] col_q [SCREENS];
	logic [RW-1:0] row_q [SCREENS];

	logic [AW-1:0] base_q, base_d;
	logic [AW-1:0] line_q, line_d;
	logic [AW-1:0] rd_q, rd_d;
	logic [AW-1:0] wr_q, wr_d;
	logic [NW-1:0] cnt_q, cnt_d;
	logic          pend_q, pend_d;
	logic          scr_q, scr_d;
	logic [15:0]   cell_q, cell_d;

	logic [15:0]   mem [DEPTH];
	logic [15:0]   mem_rd_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [15:0]   mem_wd;

	logic [SW-1:0]             sidx;
	logic                      scr_ok, rd_ok, newline;
	logic [ttcw_pkg::ATTR_W-1:0] attr_sel;
	logic [CW-1:0]             cur_col, col_d;
	logic [RW-1:0]             cur_row, row_d;
	logic [CW:0]               col_inc;
	logic [RW:0]               row_inc;
	logic                      wrap, row_hit, adv, cur_we;
	logic [AW-1:0]             addr, col_pick;

	assign sidx     = SW'(item_q.screen);
	assign scr_ok   = 32'(item_q.screen) < SCREENS;
	assign rd_ok    = (32'(item_q.row) < ROWS) && (32'(item_q.col) < COLUMNS);
	assign newline  = (item_q.chr == ttcw_pkg::CH_NEWLINE) ||
	                  (item_q.chr == ttcw_pkg::CH_RETURN);
	assign attr_sel = (item_q.screen == 2'd1) ? attr[ttcw_pkg::REG_ATTR1] :
	                  (item_q.screen == 2'd2) ? attr[ttcw_pkg::REG_ATTR2] :
	                                            attr[ttcw_pkg::REG_ATTR0];
	assign cur_col  = col_q[sidx];
	assign cur_row  = row_q[sidx];
	assign col_inc  = {1'b0, cur_col} + (CW+1)'(1);
	assign row_inc  = {1'b0, cur_row} + (RW+1)'(1);
	assign wrap     = col_inc == (CW+1)'(COLUMNS);
	assign row_hit  = row_inc == (RW+1)'(ROWS);
	assign adv      = newline || wrap;
	assign col_pick = (item_q.kind == ttcw_pkg::KIND_READ) ? AW'(item_q.col) : AW'(cur_col);
	assign addr     = base_q + line_q + col_pick;

	assign item_ready = state_q == ttcw_pkg::ST_IDLE;
	assign res_valid  = state_q == ttcw_pkg::ST_DONE;

	always_comb begin
		state_d = state_q;
		item_d  = item_q;
		base_d  = base_q;
		line_d  = line_q;
		rd_d    = rd_q;
		wr_d    = wr_q;
		cnt_d   = cnt_q;
		pend_d  = pend_q;
		scr_d   = scr_q;
		cell_d  = cell_q;
		cur_we  = 1'b0;
		col_d   = cur_col;
		row_d   = cur_row;
		mem_we  = 1'b0;
		mem_wa  = wr_q;
		mem_wd  = {attr_sel, ttcw_pkg::CH_SPACE};
		mem_re  = 1'b0;
		mem_ra  = rd_q;
		unique case (state_q)
			ttcw_pkg::ST_IDLE: begin
				if (item_valid) begin
					item_d  = item;
					scr_d   = 1'b0;
					cell_d  = '0;
					pend_d  = 1'b0;
					state_d = ttcw_pkg::ST_PREP;
				end
			end
			ttcw_pkg::ST_PREP: begin
				base_d = AW'(32'(sidx) * CELLS);
				if (item_q.kind == ttcw_pkg::KIND_READ) begin
					line_d = AW'(32'(item_q.row) * COLUMNS);
				end else begin
					line_d = AW'(32'(cur_row) * COLUMNS);
				end
				state_d = scr_ok ? ttcw_pkg::ST_CALC : ttcw_pkg::ST_DONE;
			end
			ttcw_pkg::ST_CALC: begin
				rd_d    = base_q + AW'(COLUMNS);
				wr_d    = base_q;
				state_d = ttcw_pkg::ST_DONE;
				case (ttcw_pkg::kind_t'(item_q.kind))
					ttcw_pkg::KIND_PUT: begin
						cur_we = 1'b1;
						if (!newline) begin
							mem_we = 1'b1;
							mem_wa = addr;
							mem_wd = {attr_sel, item_q.chr};
						end
						col_d = (adv) ? '0 : col_inc[CW-1:0];
						if (adv) begin
							if (row_hit) begin
								row_d   = RW'(ROWS - 1);
								scr_d   = 1'b1;
								cnt_d   = NW'((ROWS - 1) * COLUMNS);
								state_d = ttcw_pkg::ST_COPY;
							end else begin
								row_d = row_inc[RW-1:0];
							end
						end
					end
					ttcw_pkg::KIND_CLEAR: begin
						cur_we  = 1'b1;
						col_d   = '0;
						row_d   = '0;
						cnt_d   = NW'(CELLS);
						state_d = ttcw_pkg::ST_FILL;
					end
					ttcw_pkg::KIND_READ: begin
						if (rd_ok) begin
							mem_re  = 1'b1;
							mem_ra  = addr;
							state_d = ttcw_pkg::ST_RDWAIT;
						end
					end
					default: begin
						state_d = ttcw_pkg::ST_DONE;
					end
				endcase
			end
			ttcw_pkg::ST_COPY: begin
				// read one row below, write back what the previous read returned
				mem_re = 1'b1;
				rd_d   = rd_q + AW'(1);
				cnt_d  = cnt_q - NW'(1);
				pend_d = 1'b1;
				if (pend_q) begin
					mem_we = 1'b1;
					mem_wd = mem_rd_q;
					wr_d   = wr_q + AW'(1);
				end
				if (cnt_q == NW'(1)) begin
					state_d = ttcw_pkg::ST_DRAIN;
				end
			end
			ttcw_pkg::ST_DRAIN: begin
				mem_we  = 1'b1;
				mem_wd  = mem_rd_q;
				wr_d    = wr_q + AW'(1);
				pend_d  = 1'b0;
				cnt_d   = NW'(COLUMNS);
				state_d = ttcw_pkg::ST_FILL;
			end
			ttcw_pkg::ST_FILL: begin
				mem_we = 1'b1;
				wr_d   = wr_q + AW'(1);
				cnt_d  = cnt_q - NW'(1);
				if (cnt_q == NW'(1)) begin
					state_d = ttcw_pkg::ST_DONE;
				end
			end
			ttcw_pkg::ST_RDWAIT: begin
				cell_d  = mem_rd_q;
				state_d = ttcw_pkg::ST_DONE;
			end
			ttcw_pkg::ST_DONE: begin
				if (res_ready) begin
					state_d = ttcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ttcw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttcw_pkg::ST_IDLE;
			pend_q  <= 1'b0;
			for (int i = 0; i < SCREENS; i++) begin
				col_q[i] <= '0;
				row_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			if (cur_we) begin
				col_q[sidx] <= col_d;
				row_q[sidx] <= row_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		base_q <= base_d;
		line_q <= line_d;
		rd_q   <= rd_d;
		wr_q   <= wr_d;
		cnt_q  <= cnt_d;
		scr_q  <= scr_d;
		cell_q <= cell_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_ra];
		end
	end

	always_comb begin
		res = '0;
		if (scr_ok) begin
			res.cur_col    = ttcw_pkg::RCOL_W'(cur_col);
			res.cur_row    = ttcw_pkg::RROW_W'(cur_row);
			res.cur_linear = ttcw_pkg::LIN_W'(32'(cur_row) * COLUMNS + 32'(cur_col));
			res.cell_char  = cell_q[7:0];
			res.cell_attr  = cell_q[15:8];
			res.scrolled   = scr_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/text_terminal_char_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_terminal_char_writer_top
// Multi-screen text console writer with cursor, wrap, scroll and clear.
// ----------------------------------------------------------------------------
// Usage:
//   cmd   valid/ready channel; one transfer is one item: put a character,
//         clear a screen or read one cell of a screen.
//   rsp   valid/ready channel; exactly one transfer per item, in order,
//         carrying the cursor after the item and the read cell.
//   cfg   plain write port for the per-screen attribute bytes; write it
//         only while no item is in flight.
// Timing: the sequencer takes one item at a time. A plain put or a newline
//   passes through PREP and CALC to DONE; an in-range read also waits in
//   RDWAIT for the memory. A put that scrolls copies the screen one cell per
//   cycle through the memory's read and write ports (COPY, DRAIN), then
//   blanks the last row in FILL. A clear writes one cell per cycle in FILL.
// Reset: cursors go home and attributes return to 5, 2, 3. The cell memory
//   is not cleared; clear a screen before reading it.
// Stall: a held response sits in the output register; the sequencer parks
//   its finished result until that register frees, and cmd.ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module text_terminal_char_writer_top #(
	parameter int COLUMNS = ttcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = ttcw_pkg::ROWS_DEF,
	parameter int SCREENS = ttcw_pkg::SCREENS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	ttcw_cmd_if.sink                                cmd,
	ttcw_rsp_if.source                              rsp,
	input  wire logic                               cfg_we,
	input  wire logic [ttcw_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [ttcw_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [ttcw_pkg::NUM_REGS-1:0][ttcw_pkg::ATTR_W-1:0] attr_q;

	ttcw_pkg::item_t   item;
	ttcw_pkg::result_t res, rsp_q;
	logic              item_ready;
	logic              res_valid, res_ready;
	logic              out_valid_q;

	// Attribute registers; unknown indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q[ttcw_pkg::REG_ATTR0] <= ttcw_pkg::ATTR0_RST;
			attr_q[ttcw_pkg::REG_ATTR1] <= ttcw_pkg::ATTR1_RST;
			attr_q[ttcw_pkg::REG_ATTR2] <= ttcw_pkg::ATTR2_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ttcw_pkg::REG_ATTR0: attr_q[ttcw_pkg::REG_ATTR0] <= cfg_data;
				ttcw_pkg::REG_ATTR1: attr_q[ttcw_pkg::REG_ATTR1] <= cfg_data;
				ttcw_pkg::REG_ATTR2: attr_q[ttcw_pkg::REG_ATTR2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Gather the command payload into one item word.
	assign item.kind   = cmd.kind;
	assign item.screen = cmd.screen_sel;
	assign item.chr    = cmd.char_byte;
	assign item.row    = cmd.read_row;
	assign item.col    = cmd.read_col;
	assign cmd.ready   = item_ready;

	ttcw_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.SCREENS (SCREENS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (cmd.valid),
		.item_ready (item_ready),
		.item       (item),
		.attr       (attr_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// Output register: take a new result when empty or being drained.
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.cur_col    = rsp_q.cur_col;
	assign rsp.cur_row    = rsp_q.cur_row;
	assign rsp.cur_linear = rsp_q.cur_linear;
	assign rsp.cell_char  = rsp_q.cell_char;
	assign rsp.cell_attr  = rsp_q.cell_attr;
	assign rsp.scrolled   = rsp_q.scrolled;

	// Sequencer goes busy right after it takes an item.
	`ASSERT_NXT(a_busy_after_accept, cmd.valid && cmd.ready, !cmd.ready)
	// A result handed over always shows up on the response channel.
	`ASSERT_NXT(a_result_lands, res_valid && res_ready, rsp.valid)
	// A scroll always leaves the cursor on the last row.
	`ASSERT_IMP(a_scroll_last_row, rsp.valid && rsp.scrolled, rsp.cur_row == 5'(ROWS - 1))

endmodule

`default_nettype wire

// ===== tb/text_terminal_char_writer_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_terminal_char_writer_top_test
// Self-checking bench for the multi-screen text console writer.
// A table of hand-picked items runs first: reset state, out-of-range screens
// and cells, the unused kind, home and newline positions. Random traffic
// follows, shaped as text runs, newline runs and read bursts so that wrap and
// scroll get real exercise. A per-command model of the screens and cursors
// predicts each response not typed in the table; the attribute registers
// are reprogrammed between phases of varying back-pressure.
// ----------------------------------------------------------------------------

module text_terminal_char_writer_top_test;
	import ttcw_pkg::*;

	localparam int COLUMNS = COLUMNS_DEF;
	localparam int ROWS    = ROWS_DEF;
	localparam int SCREENS = SCREENS_DEF;

	// codes the package leaves unnamed: the spare kind, the screen past the
	// last one and the register index past the list
	localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
	localparam logic [SCREEN_W-1:0]  SCREEN_NONE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 190;
	localparam int DRAIN_CYCLES    = 20;
	// worst case is every item scrolling under full back-pressure; take that
	// several times over
	localparam int CYCLE_LIMIT     = 20_000_000;
	localparam int DIR_ROWS        = 24;

	typedef struct packed {
		item_t   item;
		logic    typed;
		result_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	ttcw_cmd_if cmd_ch();
	ttcw_rsp_if rsp_ch();

	text_terminal_char_writer_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Screen model: cursors, cells and attribute registers
	// ------------------------------------------------------------------------
	int          cursor_x [SCREENS];
	int          cursor_y [SCREENS];
	logic [15:0] cell_mem [SCREENS][ROWS*COLUMNS];
	logic [7:0]  attr_reg [SCREENS];

	result_t awaited_status_q [$];

	int send_idle_pct;
	int rsp_stall_pct;
	int effective_items;
	int mismatches;
	int transfers;
	int cycle_cnt;

	// Advance the model by one command and return the response it implies.
	function automatic result_t console_step(input item_t it);
		result_t     r;
		int          s;
		int          i;
		logic [15:0] blank;
		logic [15:0] cell_word;
		r = '0;
		s = it.screen;
		if (s >= SCREENS)
			return r;
		blank = {attr_reg[s], CH_SPACE};
		case (it.kind)
		KIND_PUT: begin
			if (it.chr == CH_NEWLINE || it.chr == CH_RETURN) begin
				cursor_x[s] = 0;
				cursor_y[s] = cursor_y[s] + 1;
			end else begin
				cell_mem[s][cursor_y[s]*COLUMNS + cursor_x[s]] = {attr_reg[s], it.chr};
				cursor_x[s] = cursor_x[s] + 1;
				if (cursor_x[s] >= COLUMNS) begin
					cursor_x[s] = 0;
					cursor_y[s] = cursor_y[s] + 1;
				end
			end
			// past the bottom: shift every row up and blank the last one
			if (cursor_y[s] >= ROWS) begin
				for (i = 0; i < (ROWS-1)*COLUMNS; i++)
					cell_mem[s][i] = cell_mem[s][i+COLUMNS];
				for (i = (ROWS-1)*COLUMNS; i < ROWS*COLUMNS; i++)
					cell_mem[s][i] = blank;
				cursor_y[s] = ROWS - 1;
				r.scrolled = 1'b1;
			end
		end
		KIND_CLEAR: begin
			for (i = 0; i < ROWS*COLUMNS; i++)
				cell_mem[s][i] = blank;
			cursor_x[s] = 0;
			cursor_y[s] = 0;
		end
		KIND_READ: begin
			if (it.row < ROWS && it.col < COLUMNS) begin
				cell_word = cell_mem[s][it.row*COLUMNS + it.col];
				r.cell_char = cell_word[7:0];
				r.cell_attr = cell_word[15:8];
			end
		end
		default: ;
		endcase
		r.cur_col    = RCOL_W'(cursor_x[s]);
		r.cur_row    = RROW_W'(cursor_y[s]);
		r.cur_linear = LIN_W'(cursor_y[s]*COLUMNS + cursor_x[s]);
		return r;
	endfunction

	// Every field random, the don't-care ones included.
	function automatic item_t scramble();
		item_t it;
		it.kind   = KIND_W'($urandom_range(0, 3));
		it.screen = SCREEN_W'($urandom_range(0, 3));
		it.chr    = CHAR_W'($urandom_range(0, 255));
		it.row    = RROW_W'($urandom_range(0, 31));
		it.col    = RCOL_W'($urandom_range(0, 127));
		return it;
	endfunction

	// ------------------------------------------------------------------------
	// Clock, watchdog, receiver back-pressure
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Stall the response side at random.
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
	end

	// ------------------------------------------------------------------------
	// Response checker: each transfer against the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = '{rsp_ch.cur_col, rsp_ch.cur_row, rsp_ch.cur_linear,
				rsp_ch.cell_char, rsp_ch.cell_attr, rsp_ch.scrolled};
			transfers++;
			if (awaited_status_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("transfer %0d: response with nothing awaited", transfers);
			end else begin
				want = awaited_status_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"transfer %0d: expected col %0d row %0d lin %0d ",
							"char %h attr %h scr %0d, got col %0d row %0d lin %0d ",
							"char %h attr %h scr %0d"}, transfers,
							want.cur_col, want.cur_row, want.cur_linear,
							want.cell_char, want.cell_attr, want.scrolled,
							got.cur_col, got.cur_row, got.cur_linear,
							got.cell_char, got.cell_attr, got.scrolled);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Command driver
	// ------------------------------------------------------------------------

	// Present one command on the falling edge, hold it until the transfer,
	// then queue its expected response. A typed row queues the hand-written
	// answer instead, but the model still advances.
	task automatic issue(input item_t it, input bit typed, input result_t want);
		result_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.kind       <= it.kind;
		cmd_ch.screen_sel <= it.screen;
		cmd_ch.char_byte  <= it.chr;
		cmd_ch.read_row   <= it.row;
		cmd_ch.read_col   <= it.col;
		do
			@(posedge clk);
		while (cmd_ch.ready !== 1'b1);
		predicted = console_step(it);
		awaited_status_q.push_back(typed ? want : predicted);
		if (it.screen < SCREENS && it.kind != KIND_UNUSED)
			effective_items++;
	endtask

	// Drop valid, then hold until every response is back so the block is idle.
	task automatic settle();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (awaited_status_q.size() != 0)
			@(posedge clk);
	endtask

	// Program all three attribute registers; optionally poke the spare index,
	// which the block must ignore.
	task automatic program_attrs(input logic [7:0] a0, input logic [7:0] a1,
		input logic [7:0] a2, input bit poke_spare);
		logic [7:0] vals [SCREENS];
		int         i;
		vals = '{a0, a1, a2};
		for (i = 0; i < SCREENS; i++) begin
			@(negedge clk);
			cfg_we   <= 1'b1;
			cfg_idx  <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			attr_reg[i] = vals[i];
		end
		if (poke_spare) begin
			@(negedge clk);
			cfg_idx  <= REG_SPARE;
			cfg_data <= CFG_DATA_W'($urandom_range(0, 255));
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random traffic built from short sequences with random content.
	task automatic run_random(input int target);
		item_t it;
		int    pick;
		int    s;
		int    len;
		int    k;
		int    stop;
		stop = effective_items + target;
		while (effective_items < stop) begin
			pick = $urandom_range(0, 99);
			s    = $urandom_range(0, SCREENS-1);
			if (pick < 45) begin
				// text run, now and then long enough to wrap a whole row
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 100)
					: $urandom_range(1, 30);
				for (k = 0; k < len; k++) begin
					it        = scramble();
					it.kind   = KIND_PUT;
					it.screen = SCREEN_W'(s);
					case ($urandom_range(0, 15))
					0:       it.chr = $urandom_range(0, 1) ? CH_NEWLINE : CH_RETURN;
					1, 2, 3: it.chr = CHAR_W'($urandom_range(0, 255));
					default: it.chr = CHAR_W'($urandom_range(32, 126));
					endcase
					issue(it, 1'b0, '0);
				end
			end else if (pick < 60) begin
				// newline run: walks the cursor down and scrolls at the bottom
				len = $urandom_range(1, 6);
				for (k = 0; k < len; k++) begin
					it        = scramble();
					it.kind   = KIND_PUT;
					it.screen = SCREEN_W'(s);
					it.chr    = $urandom_range(0, 1) ? CH_NEWLINE : CH_RETURN;
					issue(it, 1'b0, '0);
				end
			end else if (pick < 85) begin
				// read burst; every screen was cleared in the directed part,
				// so any in-range cell holds a written value
				len = $urandom_range(1, 6);
				for (k = 0; k < len; k++) begin
					it        = scramble();
					it.kind   = KIND_READ;
					it.screen = SCREEN_W'(s);
					case ($urandom_range(0, 7))
					0: it.row = RROW_W'($urandom_range(ROWS, 31));
					1: it.col = RCOL_W'($urandom_range(COLUMNS, 127));
					2: begin
						it.row = RROW_W'(cursor_y[s]);
						it.col = RCOL_W'($urandom_range(0, cursor_x[s]));
					end
					default: begin
						it.row = RROW_W'($urandom_range(0, ROWS-1));
						it.col = RCOL_W'($urandom_range(0, COLUMNS-1));
					end
					endcase
					issue(it, 1'b0, '0);
				end
			end else if (pick < 89) begin
				it        = scramble();
				it.kind   = KIND_CLEAR;
				it.screen = SCREEN_W'(s);
				issue(it, 1'b0, '0);
			end else begin
				// noise: the missing screen with any kind, or the spare kind
				it = scramble();
				if ($urandom_range(0, 1))
					it.screen = SCREEN_NONE;
				else
					it.kind = KIND_UNUSED;
				issue(it, 1'b0, '0);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Directed table: typed rows carry answers readable at a glance, the rest
	// go through the model
	// ------------------------------------------------------------------------
	dir_row_t dir_tbl [DIR_ROWS];

	initial begin
		dir_tbl = '{
			// out-of-range cell on a screen not yet cleared: cursor at home
			'{'{KIND_READ,   2'd0,        8'h00,      5'd31, 7'd127}, 1'b1, '0},
			// the missing screen answers all zero for every kind
			'{'{KIND_PUT,    SCREEN_NONE, 8'hFF,      5'd31, 7'd127}, 1'b1, '0},
			'{'{KIND_CLEAR,  SCREEN_NONE, 8'h00,      5'd0,  7'd0},   1'b1, '0},
			'{'{KIND_READ,   SCREEN_NONE, 8'h00,      5'd0,  7'd0},   1'b1, '0},
			// spare kind: no change, cursor still home
			'{'{KIND_UNUSED, 2'd0,        8'hFF,      5'd31, 7'd127}, 1'b1, '0},
			'{'{KIND_CLEAR,  2'd0,        8'hFF,      5'd31, 7'd127}, 1'b1, '0},
			'{'{KIND_CLEAR,  2'd1,        8'h00,      5'd0,  7'd0},   1'b1, '0},
			'{'{KIND_CLEAR,  2'd2,        8'h55,      5'd10, 7'd42},  1'b1, '0},
			// byte extremes advance the cursor
			'{'{KIND_PUT,    2'd0,        8'h00,      5'd0,  7'd0},   1'b1,
				'{7'd1, 5'd0, 11'd1, 8'h00, 8'h00, 1'b0}},
			'{'{KIND_PUT,    2'd0,        8'hFF,      5'd0,  7'd0},   1'b1,
				'{7'd2, 5'd0, 11'd2, 8'h00, 8'h00, 1'b0}},
			'{'{KIND_READ,   2'd0,        8'h00,      5'd0,  7'd0},   1'b1,
				'{7'd2, 5'd0, 11'd2, 8'h00, ATTR0_RST, 1'b0}},
			'{'{KIND_READ,   2'd0,        8'h00,      5'd0,  7'd1},   1'b1,
				'{7'd2, 5'd0, 11'd2, 8'hFF, ATTR0_RST, 1'b0}},
			// far corner holds the blank left by the clear
			'{'{KIND_READ,   2'd0,        8'h00,      5'd24, 7'd79},  1'b1,
				'{7'd2, 5'd0, 11'd2, CH_SPACE, ATTR0_RST, 1'b0}},
			// both newline codes
			'{'{KIND_PUT,    2'd0,        CH_NEWLINE, 5'd0,  7'd0},   1'b1,
				'{7'd0, 5'd1, 11'd80, 8'h00, 8'h00, 1'b0}},
			'{'{KIND_PUT,    2'd0,        CH_RETURN,  5'd0,  7'd0},   1'b1,
				'{7'd0, 5'd2, 11'd160, 8'h00, 8'h00, 1'b0}},
			'{'{KIND_PUT,    2'd0,        CH_SPACE,   5'd0,  7'd0},   1'b0, '0},
			'{'{KIND_READ,   2'd0,        8'h00,      5'd2,  7'd0},   1'b0, '0},
			// the other screens use their own attributes
			'{'{KIND_PUT,    2'd1,        8'h41,      5'd3,  7'd3},   1'b0, '0},
			'{'{KIND_READ,   2'd1,        8'h00,      5'd0,  7'd0},   1'b0, '0},
			'{'{KIND_PUT,    2'd2,        8'h7A,      5'd0,  7'd0},   1'b0, '0},
			'{'{KIND_READ,   2'd2,        8'h00,      5'd0,  7'd0},   1'b0, '0},
			// just past the last row and the last column
			'{'{KIND_READ,   2'd2,        8'h00,      5'd25, 7'd0},   1'b0, '0},
			'{'{KIND_READ,   2'd2,        8'h00,      5'd0,  7'd80},  1'b0, '0},
			'{'{KIND_UNUSED, 2'd2,        8'h0A,      5'd1,  7'd1},   1'b0, '0}
		};
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int         i;
		int         p;
		logic [7:0] a0;
		logic [7:0] a1;
		logic [7:0] a2;

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = '0;
		cfg_data          = '0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.kind       = '0;
		cmd_ch.screen_sel = '0;
		cmd_ch.char_byte  = '0;
		cmd_ch.read_row   = '0;
		cmd_ch.read_col   = '0;
		rsp_ch.ready      = 1'b0;
		send_idle_pct     = 0;
		rsp_stall_pct     = 0;
		effective_items   = 0;
		mismatches        = 0;
		transfers         = 0;
		cycle_cnt         = 0;

		// model reset: cursors home, attributes at their reset values
		for (i = 0; i < SCREENS; i++) begin
			cursor_x[i] = 0;
			cursor_y[i] = 0;
		end
		attr_reg = '{ATTR0_RST, ATTR1_RST, ATTR2_RST};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, no idling
		for (i = 0; i < DIR_ROWS; i++)
			issue(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].want);
		settle();

		// random phases: cycle through the idling profiles twice, each with a
		// fresh set of attributes; the first two take the extremes
		for (p = 0; p < PHASES; p++) begin
			case (p % 4)
			0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
			1: begin send_idle_pct = 84; rsp_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  rsp_stall_pct = 84; end
			default: begin send_idle_pct = 31; rsp_stall_pct = 31; end
			endcase
			if (p == 0) begin
				a0 = 8'h00; a1 = 8'h00; a2 = 8'h00;
			end else if (p == 1) begin
				a0 = 8'hFF; a1 = 8'hFF; a2 = 8'hFF;
			end else begin
				a0 = 8'($urandom_range(0, 255));
				a1 = 8'($urandom_range(0, 255));
				a2 = 8'($urandom_range(0, 255));
			end
			program_attrs(a0, a1, a2, p == 3 || p == 6);
			run_random(ITEMS_PER_PHASE);
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += awaited_status_q.size();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
